// ----- rtl/best_score_window_search_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the best-score window search block
// Shared property wrappers; clk and rst_n must be in scope where used.
// ----------------------------------------------------------------------------
`ifndef BEST_SCORE_WINDOW_SEARCH_MACROS_SVH
`define BEST_SCORE_WINDOW_SEARCH_MACROS_SVH

// Checked only outside reset
`define BSWS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included
`define BSWS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/bsws_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsws_pkg
// Types and constants shared by the best-score window search modules.
// ----------------------------------------------------------------------------
package bsws_pkg;

  // Defaults for the top-level parameters
  localparam int WINDOW_DEF   = 11;
  localparam int ALPHABET_DEF = 32;

  // Fixed field widths
  localparam int CODE_W  = 5;
  localparam int SCORE_W = 8;
  localparam int SUM_W   = 12;
  localparam int POS_W   = 24;

  // Input word kinds
  typedef enum logic [1:0] {
    KIND_TABLE  = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_PAIR   = 2'd2,
    KIND_IDLE   = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t                     kind;
    logic [CODE_W-1:0]         residue_query;
    logic [CODE_W-1:0]         residue_subject;
    logic signed [SCORE_W-1:0] table_value;
    logic signed [SCORE_W-1:0] position_score;
    logic [POS_W-1:0]          query_offset;
    logic [POS_W-1:0]          query_extent;
    logic [POS_W-1:0]          query_end;
    logic [POS_W-1:0]          subject_extent;
    logic                      last;
  } in_word_t;

  typedef struct packed {
    logic [POS_W-1:0]        start_offset;
    logic signed [SUM_W-1:0] best_score;
    logic                    short_case;
  } out_word_t;

  // Control and payload handed from the issue stage to the window stage
  typedef struct packed {
    logic                      is_header;
    logic                      is_short;
    logic                      last;
    logic                      full;
    logic                      in_range;
    logic signed [SCORE_W-1:0] position_score;
    logic [POS_W-1:0]          offset;
    logic [POS_W-1:0]          short_start;
  } step_t;

endpackage

// ----- rtl/bsws_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsws_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data that holds while read enable is low.
// ----------------------------------------------------------------------------
module bsws_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/bsws_window.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsws_window
// Window stage: forms the pair score, updates the running window sum and the
// best window, and builds the result word.
// ----------------------------------------------------------------------------
module bsws_window #(
  parameter int WINDOW = bsws_pkg::WINDOW_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              go,
  input  bsws_pkg::step_t                   step,
  input  logic                              position_based,
  input  logic [bsws_pkg::SCORE_W-1:0]      table_rd,
  input  logic [bsws_pkg::SCORE_W-1:0]      old_rd,
  output logic                              emit,
  output bsws_pkg::out_word_t               result,
  output logic [bsws_pkg::SCORE_W-1:0]      score
);

  import bsws_pkg::*;

  localparam logic [POS_W-1:0] HALF = POS_W'(WINDOW / 2);

  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic signed [SUM_W-1:0] max_r, max_nxt;
  logic [POS_W-1:0]        mpos_r, mpos_nxt;
  logic [POS_W-1:0]        pos_r, pos_nxt;
  logic [POS_W-1:0]        start_r, start_nxt;

  logic signed [SUM_W-1:0] score_x, old_x, pair_sum;
  logic                    take;

  // Pair score: per-position value or table entry; in table mode, codes off the alphabet give 0
  always_comb begin
    if (position_based) begin
      score = step.position_score;
    end else if (step.in_range) begin
      score = table_rd;
    end else begin
      score = '0;
    end
  end

  assign score_x  = {{(SUM_W-SCORE_W){score[SCORE_W-1]}}, score};
  assign old_x    = step.full ? {{(SUM_W-SCORE_W){old_rd[SCORE_W-1]}}, old_rd} : '0;
  assign pair_sum = sum_r - old_x + score_x;

  // While filling every window counts; after that only a strictly better one
  assign take = !step.full || (pair_sum > max_r);

  always_comb begin
    if (step.is_header) begin
      sum_nxt   = '0;
      max_nxt   = '0;
      mpos_nxt  = '0;
      pos_nxt   = step.offset;
      start_nxt = step.offset;
    end else begin
      sum_nxt   = pair_sum;
      max_nxt   = take ? pair_sum : max_r;
      mpos_nxt  = take ? pos_r : mpos_r;
      pos_nxt   = pos_r + 1'b1;
      start_nxt = start_r;
    end
  end

  // Result word
  always_comb begin
    emit = step.is_header ? step.is_short : step.last;
    if (step.is_header) begin
      result.start_offset = step.short_start;
      result.best_score   = '0;
      result.short_case   = 1'b1;
    end else begin
      result.start_offset = (max_nxt > 0) ? (mpos_nxt - HALF) : start_r;
      result.best_score   = max_nxt;
      result.short_case   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      max_r   <= '0;
      mpos_r  <= '0;
      pos_r   <= '0;
      start_r <= '0;
    end else if (go) begin
      sum_r   <= sum_nxt;
      max_r   <= max_nxt;
      mpos_r  <= mpos_nxt;
      pos_r   <= pos_nxt;
      start_r <= start_nxt;
    end
  end

endmodule

// ----- rtl/best_score_window_search.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// best_score_window_search
// Finds the middle of the best-scoring window along an ungapped alignment.
// ----------------------------------------------------------------------------
// One input word is taken every cycle unless the input stalls. A residue pair
// issues its score-table read and its window-slot read at acceptance; once the
// pair reaches the window stage register, that stage adds the new score, drops the
// score leaving the window and compares with the best sum, so a word follows a
// word without a gap. A result is registered in the output register; the input
// stalls only while a finished result waits there and the next result is due.
// The score table holds no valid bits and needs no clearing after reset: every
// entry must be written before a pair reads it. The user must write configuration
// (position-based scoring) while idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module best_score_window_search #(
  parameter int WINDOW        = bsws_pkg::WINDOW_DEF,
  parameter int ALPHABET_SIZE = bsws_pkg::ALPHABET_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bsws_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bsws_pkg::out_word_t out_data,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data
);

  import bsws_pkg::*;

  `include "best_score_window_search_macros.svh"

  localparam int TDEPTH = ALPHABET_SIZE * ALPHABET_SIZE;
  localparam int TAW    = $clog2(TDEPTH);
  localparam int HW     = $clog2(WINDOW);
  localparam int FW     = $clog2(WINDOW + 1);

  // Issue stage state
  logic          active_r, active_nxt;
  logic [HW-1:0] head_r, head_nxt, head_inc;
  logic [FW-1:0] fill_r, fill_nxt;
  logic          pb_r;

  // Window stage pipeline register
  logic          s1_valid_r;
  step_t         s1_step_r, step_nxt;
  logic [HW-1:0] s1_head_r;
  logic          s1_go, s1_load;

  // Output register
  logic      out_valid_r;
  out_word_t out_data_r;

  logic                 in_accept, code_ok, win_full, long_hdr;
  logic [31:0]          addr_wide;
  logic [TAW-1:0]       tbl_addr;
  logic                 tbl_we, rd_en;
  logic [SCORE_W-1:0]   tbl_rd, old_rd, score;
  logic                 win_we, emit;
  out_word_t            result;

  // Handshake
  assign in_accept = in_valid && in_ready;
  assign s1_go     = s1_valid_r && (!emit || !out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || s1_go;

  // Table addressing and issue-side decode
  assign code_ok   = (32'(in_data.residue_query) < 32'(ALPHABET_SIZE)) &&
                     (32'(in_data.residue_subject) < 32'(ALPHABET_SIZE));
  assign addr_wide = 32'(in_data.residue_query) * 32'(ALPHABET_SIZE) +
                     32'(in_data.residue_subject);
  assign tbl_addr  = addr_wide[TAW-1:0];
  assign win_full  = (fill_r == FW'(WINDOW));
  assign long_hdr  = (in_data.query_extent > POS_W'(WINDOW));
  assign head_inc  = (head_r == HW'(WINDOW - 1)) ? '0 : head_r + 1'b1;

  always_comb begin
    active_nxt = active_r;
    head_nxt   = head_r;
    fill_nxt   = fill_r;
    s1_load    = 1'b0;
    tbl_we     = 1'b0;
    rd_en      = 1'b0;
    if (in_accept) begin
      unique case (in_data.kind)
        KIND_TABLE: begin
          tbl_we = code_ok;
        end
        KIND_HEADER: begin
          active_nxt = long_hdr;
          head_nxt   = '0;
          fill_nxt   = '0;
          s1_load    = 1'b1;
        end
        KIND_PAIR: begin
          // pairs outside an open alignment are dropped here
          if (active_r) begin
            rd_en    = 1'b1;
            s1_load  = 1'b1;
            head_nxt = head_inc;
            if (!win_full) begin
              fill_nxt = fill_r + 1'b1;
            end
            if (in_data.last) begin
              active_nxt = 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Word handed to the window stage
  always_comb begin
    step_nxt.is_header      = (in_data.kind == KIND_HEADER);
    step_nxt.is_short       = !long_hdr;
    step_nxt.last           = in_data.last;
    step_nxt.full           = win_full;
    step_nxt.in_range       = code_ok;
    step_nxt.position_score = in_data.position_score;
    step_nxt.offset         = in_data.query_offset;
    step_nxt.short_start    = in_data.query_offset + {1'b0, in_data.query_extent[POS_W-1:1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r   <= 1'b0;
      head_r     <= '0;
      fill_r     <= '0;
      pb_r       <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
      head_r   <= head_nxt;
      fill_r   <= fill_nxt;
      if (cfg_wr_en) begin
        pb_r <= cfg_wr_data;
      end
      if (in_ready) begin
        s1_valid_r <= s1_load;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      s1_step_r <= step_nxt;
      s1_head_r <= head_r;
    end
  end

  // Substitution score table
  bsws_ram #(
    .WIDTH (SCORE_W),
    .DEPTH (TDEPTH)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_addr),
    .wdata (in_data.table_value),
    .re    (rd_en),
    .raddr (tbl_addr),
    .rdata (tbl_rd)
  );

  // Ring of the scores in the current window
  assign win_we = s1_go && !s1_step_r.is_header;

  bsws_ram #(
    .WIDTH (SCORE_W),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (win_we),
    .waddr (s1_head_r),
    .wdata (score),
    .re    (rd_en),
    .raddr (head_r),
    .rdata (old_rd)
  );

  bsws_window #(
    .WINDOW (WINDOW)
  ) u_window (
    .clk            (clk),
    .rst_n          (rst_n),
    .go             (s1_go),
    .step           (s1_step_r),
    .position_based (pb_r),
    .table_rd       (tbl_rd),
    .old_rd         (old_rd),
    .emit           (emit),
    .result         (result),
    .score          (score)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && emit) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks
  `BSWS_ASSERT(a_no_overwrite, s1_go && emit |-> !out_valid_r || out_ready, "result register overwritten")
  `BSWS_ASSERT(a_fill_bound, fill_r <= FW'(WINDOW), "window fill count beyond window")
  `BSWS_ASSERT(a_ring_ports, win_we && rd_en |-> s1_head_r != head_r, "ring read and write collide")
  `BSWS_ASSERT(a_stray_pair, in_accept && in_data.kind == KIND_PAIR && !active_r |=> !s1_valid_r, "pair outside alignment entered window stage")
  `BSWS_ASSERT_ALWAYS(a_reset_idle, rst_n && !$past(rst_n) |-> !out_valid_r && !s1_valid_r, "pipeline not idle after reset")

endmodule
